// ===== hw/rtl/wmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Wiper mode and sweep controller package
// Shared constants, codes, register layout and the sweep step function.
// ----------------------------------------------------------------------------
package wmsc_pkg;

  localparam int SampleBitsDef = 12;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 14;
  localparam int ThrW     = 12;
  localparam int WaitW    = 14;
  localparam int DutyW    = 7;
  localparam int ElapsedW = 9;
  localparam int TimerW   = 16;
  localparam int StepW    = 7;
  localparam int OutW     = 16;

  localparam logic [DutyW-1:0]    DutyMin     = 7'd23;
  localparam logic [DutyW-1:0]    DutyMax     = 7'd59;
  localparam logic [DutyW-1:0]    DutyTop     = 7'd127;
  localparam logic [ElapsedW-1:0] PhaseTimeMs = 9'd380;
  localparam logic [ElapsedW-1:0] ElapsedMax  = 9'd511;
  localparam logic [TimerW-1:0]   TimerMax    = 16'hFFFF;
  localparam logic [StepW-1:0]    StepLimit   = 7'd75;
  localparam int                  TickMs      = 10;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgModeOffThr  = 4'd0,
    CfgModeLowThr  = 4'd1,
    CfgModeHighThr = 4'd2,
    CfgIvlShortThr = 4'd3,
    CfgIvlLongThr  = 4'd4,
    CfgShortWait   = 4'd5,
    CfgMediumWait  = 4'd6,
    CfgLongWait    = 4'd7
  } cfg_idx_e;

  localparam logic [ThrW-1:0]  RstModeOffThr  = 12'd1024;
  localparam logic [ThrW-1:0]  RstModeLowThr  = 12'd2048;
  localparam logic [ThrW-1:0]  RstModeHighThr = 12'd3072;
  localparam logic [ThrW-1:0]  RstIvlShortThr = 12'd1352;
  localparam logic [ThrW-1:0]  RstIvlLongThr  = 12'd2744;
  localparam logic [WaitW-1:0] RstShortWait   = 14'd3000;
  localparam logic [WaitW-1:0] RstMediumWait  = 14'd6000;
  localparam logic [WaitW-1:0] RstLongWait    = 14'd8000;

  typedef enum logic [1:0] {
    ModeOff  = 2'd0,
    ModeLow  = 2'd1,
    ModeHigh = 2'd2,
    ModeInt  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    IvlShort  = 2'd0,
    IvlMedium = 2'd1,
    IvlLong   = 2'd2
  } ivl_e;

  typedef enum logic [1:0] {
    PhHold = 2'd0,
    PhRise = 2'd1,
    PhFall = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ThrW-1:0]  mode_off_thr;
    logic [ThrW-1:0]  mode_low_thr;
    logic [ThrW-1:0]  mode_high_thr;
    logic [ThrW-1:0]  ivl_short_thr;
    logic [ThrW-1:0]  ivl_long_thr;
    logic [WaitW-1:0] short_wait;
    logic [WaitW-1:0] medium_wait;
    logic [WaitW-1:0] long_wait;
  } cfg_t;

  typedef struct packed {
    mode_e                mode;
    ivl_e                 ivl;
    phase_e               phase;
    logic [DutyW-1:0]     rise_duty;
    logic [DutyW-1:0]     fall_duty;
    logic [ElapsedW-1:0]  elapsed;
    logic [TimerW-1:0]    timer;
    logic [StepW-1:0]     step_cnt;
  } state_t;

  typedef struct packed {
    logic             duty_valid;
    logic [DutyW-1:0] duty;
    mode_e            mode;
    ivl_e             ivl;
    phase_e           phase;
  } result_t;

  typedef struct packed {
    state_t           st;
    logic             wr;
    logic [DutyW-1:0] duty;
  } sweep_t;

  function automatic logic [ElapsedW-1:0] add_elapsed(input logic [ElapsedW-1:0] e);
    logic [ElapsedW:0] s;
    s = {1'b0, e} + (ElapsedW+1)'(TickMs);
    add_elapsed = (s > {1'b0, ElapsedMax}) ? ElapsedMax : s[ElapsedW-1:0];
  endfunction

  function automatic logic [TimerW-1:0] add_timer(input logic [TimerW-1:0] t);
    logic [TimerW:0] s;
    s = {1'b0, t} + (TimerW+1)'(TickMs);
    add_timer = s[TimerW] ? TimerMax : s[TimerW-1:0];
  endfunction

  // One servo step: hold enters rise, rise and fall move the duty one unit.
  function automatic sweep_t sweep_step(input state_t s);
    sweep_t r;
    r      = '0;
    r.st   = s;
    r.wr   = 1'b0;
    r.duty = '0;
    case (s.phase)
      PhHold: begin
        r.st.phase = PhRise;
      end
      PhRise: begin
        if (s.rise_duty < DutyTop) r.st.rise_duty = s.rise_duty + 7'd1;
        r.wr       = 1'b1;
        r.duty     = r.st.rise_duty;
        r.st.elapsed = add_elapsed(s.elapsed);
        if (r.st.rise_duty >= DutyMax && r.st.elapsed >= PhaseTimeMs) begin
          r.st.phase     = PhFall;
          r.st.elapsed   = '0;
          r.st.rise_duty = DutyMin;
        end
      end
      PhFall: begin
        if (s.fall_duty != '0) r.st.fall_duty = s.fall_duty - 7'd1;
        r.wr       = 1'b1;
        r.duty     = r.st.fall_duty;
        r.st.elapsed = add_elapsed(s.elapsed);
        if (r.st.fall_duty < DutyMin && r.st.elapsed >= PhaseTimeMs) begin
          r.st.phase     = PhHold;
          r.st.elapsed   = '0;
          r.st.fall_duty = DutyMax;
        end
      end
      default: begin
        // undefined phase code: enter fall
        r.st.phase = PhFall;
      end
    endcase
    sweep_step = r;
  endfunction

endpackage

// ===== hw/rtl/wmsc_step.sv =====
// ----------------------------------------------------------------------------
// Wiper tick update
// Mode and interval decode plus one tick of sweep and interval timer logic.
// ----------------------------------------------------------------------------
module wmsc_step #(
  parameter int SampleBits = wmsc_pkg::SampleBitsDef
) (
  input  wmsc_pkg::state_t        state_i,
  input  wmsc_pkg::cfg_t          cfg_i,
  input  logic                    engine_on_i,
  input  logic [SampleBits-1:0]   mode_level_i,
  input  logic [SampleBits-1:0]   interval_level_i,
  output wmsc_pkg::state_t        state_o,
  output wmsc_pkg::result_t       result_o
);

  localparam int CmpW = (SampleBits > wmsc_pkg::ThrW) ? SampleBits : wmsc_pkg::ThrW;

  logic [CmpW-1:0] mlev, ilev;
  logic [CmpW-1:0] off_thr, low_thr, high_thr, short_thr, long_thr;

  assign mlev      = CmpW'(mode_level_i);
  assign ilev      = CmpW'(interval_level_i);
  assign off_thr   = CmpW'(cfg_i.mode_off_thr);
  assign low_thr   = CmpW'(cfg_i.mode_low_thr);
  assign high_thr  = CmpW'(cfg_i.mode_high_thr);
  assign short_thr = CmpW'(cfg_i.ivl_short_thr);
  assign long_thr  = CmpW'(cfg_i.ivl_long_thr);

  always_comb begin
    wmsc_pkg::state_t                 s;
    wmsc_pkg::sweep_t                 sw;
    logic                             wr;
    logic [wmsc_pkg::DutyW-1:0]       duty;
    logic [wmsc_pkg::WaitW-1:0]       wait_ms;

    s       = state_i;
    sw      = wmsc_pkg::sweep_step(state_i);
    wr      = 1'b0;
    duty    = '0;
    wait_ms = cfg_i.medium_wait;

    if (engine_on_i) begin
      if (mlev > high_thr)      s.mode = wmsc_pkg::ModeInt;
      else if (mlev > low_thr)  s.mode = wmsc_pkg::ModeHigh;
      else if (mlev >= off_thr) s.mode = wmsc_pkg::ModeLow;
      else                      s.mode = wmsc_pkg::ModeOff;
    end

    sw = wmsc_pkg::sweep_step(s);

    case (s.mode)
      wmsc_pkg::ModeOff: begin
        // finish a sweep under way, engine or not
        if (s.phase != wmsc_pkg::PhHold) begin
          s    = sw.st;
          wr   = sw.wr;
          duty = sw.duty;
        end
      end
      wmsc_pkg::ModeLow, wmsc_pkg::ModeHigh: begin
        if (engine_on_i) begin
          s    = sw.st;
          wr   = sw.wr;
          duty = sw.duty;
        end
      end
      wmsc_pkg::ModeInt: begin
        if (engine_on_i) begin
          s.timer = wmsc_pkg::add_timer(s.timer);
          if (ilev < short_thr)     s.ivl = wmsc_pkg::IvlShort;
          else if (ilev > long_thr) s.ivl = wmsc_pkg::IvlLong;
          else                      s.ivl = wmsc_pkg::IvlMedium;
          case (s.ivl)
            wmsc_pkg::IvlShort:  wait_ms = cfg_i.short_wait;
            wmsc_pkg::IvlMedium: wait_ms = cfg_i.medium_wait;
            wmsc_pkg::IvlLong:   wait_ms = cfg_i.long_wait;
            default:             wait_ms = cfg_i.long_wait;
          endcase
          if (s.timer >= wmsc_pkg::TimerW'(wait_ms)) begin
            sw         = wmsc_pkg::sweep_step(s);
            s          = sw.st;
            wr         = sw.wr;
            duty       = sw.duty;
            s.step_cnt = s.step_cnt + 7'd1;
            if (s.step_cnt >= wmsc_pkg::StepLimit) begin
              s.timer    = '0;
              s.step_cnt = '0;
            end
          end else begin
            // waiting: park at minimum duty, timer runs double
            wr      = 1'b1;
            duty    = wmsc_pkg::DutyMin;
            s.timer = wmsc_pkg::add_timer(s.timer);
          end
        end
      end
      default: ;
    endcase

    state_o             = s;
    result_o.duty_valid = wr;
    result_o.duty       = duty;
    result_o.mode       = s.mode;
    result_o.ivl        = s.ivl;
    result_o.phase      = s.phase;
  end

endmodule

// ===== hw/rtl/wiper_mode_sweep_controller.sv =====
// ----------------------------------------------------------------------------
// Wiper mode and sweep controller
// Per-tick mode selection, servo sweep and intermittent interval timing.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake       | payload
//  s_axis   | in        | tvalid/tready   | tdata: engine_on, mode_level, interval_level
//  m_axis   | out       | tvalid/tready   | tdata: duty_valid, duty_thousandths,
//           |           |                 |        active_mode, active_interval, sweep_phase
//  cfg      | in        | cfg_valid/ready | cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while the output is not stalled. An input
// transaction lands in the input register; it then moves through the tick update
// into the output register, from which its result is taken. Reset clears the
// pipeline valids, the sweep state and the configuration registers to their
// defaults. A stalled output holds its result; the input register takes one
// more transaction and then s_axis_tready drops until the output moves.
// ----------------------------------------------------------------------------
module wiper_mode_sweep_controller #(
  parameter int SampleBits = wmsc_pkg::SampleBitsDef,
  localparam int InW = ((1 + 2 * SampleBits + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // engine_on, mode_level, interval_level (from bit 0 up)
  input  logic [InW-1:0]                s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // duty_valid, duty_thousandths, active_mode, active_interval, sweep_phase
  output logic [wmsc_pkg::OutW-1:0]     m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wmsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wmsc_pkg::CfgDataW-1:0] cfg_data_i
);

  wmsc_pkg::cfg_t    cfg_q;
  wmsc_pkg::state_t  state_q, state_d;
  wmsc_pkg::result_t result_d, result_q;

  logic                  in_valid_q;
  logic                  engine_q;
  logic [SampleBits-1:0] mlev_q, ilev_q;
  logic                  out_valid_q;
  logic                  out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_off_thr  <= wmsc_pkg::RstModeOffThr;
      cfg_q.mode_low_thr  <= wmsc_pkg::RstModeLowThr;
      cfg_q.mode_high_thr <= wmsc_pkg::RstModeHighThr;
      cfg_q.ivl_short_thr <= wmsc_pkg::RstIvlShortThr;
      cfg_q.ivl_long_thr  <= wmsc_pkg::RstIvlLongThr;
      cfg_q.short_wait    <= wmsc_pkg::RstShortWait;
      cfg_q.medium_wait   <= wmsc_pkg::RstMediumWait;
      cfg_q.long_wait     <= wmsc_pkg::RstLongWait;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wmsc_pkg::CfgModeOffThr:  cfg_q.mode_off_thr  <= cfg_data_i[wmsc_pkg::ThrW-1:0];
        wmsc_pkg::CfgModeLowThr:  cfg_q.mode_low_thr  <= cfg_data_i[wmsc_pkg::ThrW-1:0];
        wmsc_pkg::CfgModeHighThr: cfg_q.mode_high_thr <= cfg_data_i[wmsc_pkg::ThrW-1:0];
        wmsc_pkg::CfgIvlShortThr: cfg_q.ivl_short_thr <= cfg_data_i[wmsc_pkg::ThrW-1:0];
        wmsc_pkg::CfgIvlLongThr:  cfg_q.ivl_long_thr  <= cfg_data_i[wmsc_pkg::ThrW-1:0];
        wmsc_pkg::CfgShortWait:   cfg_q.short_wait    <= cfg_data_i[wmsc_pkg::WaitW-1:0];
        wmsc_pkg::CfgMediumWait:  cfg_q.medium_wait   <= cfg_data_i[wmsc_pkg::WaitW-1:0];
        wmsc_pkg::CfgLongWait:    cfg_q.long_wait     <= cfg_data_i[wmsc_pkg::WaitW-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      engine_q <= s_axis_tdata[0];
      mlev_q   <= s_axis_tdata[SampleBits:1];
      ilev_q   <= s_axis_tdata[2*SampleBits:SampleBits+1];
    end
  end

  wmsc_step #(
    .SampleBits(SampleBits)
  ) u_step (
    .state_i         (state_q),
    .cfg_i           (cfg_q),
    .engine_on_i     (engine_q),
    .mode_level_i    (mlev_q),
    .interval_level_i(ilev_q),
    .state_o         (state_d),
    .result_o        (result_d)
  );

  // sweep state advances when the tick moves into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= wmsc_pkg::ModeOff;
      state_q.ivl       <= wmsc_pkg::IvlShort;
      state_q.phase     <= wmsc_pkg::PhHold;
      state_q.rise_duty <= wmsc_pkg::DutyMin;
      state_q.fall_duty <= wmsc_pkg::DutyMax;
      state_q.elapsed   <= '0;
      state_q.timer     <= '0;
      state_q.step_cnt  <= '0;
      out_valid_q       <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) result_q <= result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, result_q.phase, result_q.ivl, result_q.mode,
                          result_q.duty, result_q.duty_valid};

endmodule

// ===== hw/rtl/wmsc_checker.sv =====
// ----------------------------------------------------------------------------
// Wiper controller port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module wmsc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [wmsc_pkg::OutW-1:0] m_axis_tdata
);

  // no result right after a reset edge
  a_no_valid_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled result holds
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no duty written means duty field zero
  a_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[7:1] == 7'd0)
    else $error("duty field set without a duty write");

  // phase and interval codes stay in their ranges
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:12] != 2'd3 && m_axis_tdata[11:10] != 2'd3)
    else $error("undefined phase or interval code");

endmodule

bind wiper_mode_sweep_controller wmsc_checker u_wmsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== test/tb_wiper_mode_sweep_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wiper mode and sweep controller testbench
// Drives ticks over the input stream and keeps its own model of the mode
// selection, servo sweep and interval timer. Every output word is checked
// field by field, in order, against the word the model expects. Threshold and
// wait registers are reprogrammed between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_wiper_mode_sweep_controller;

  localparam int TickW = 32;
  localparam logic [wmsc_pkg::CfgIdxW-1:0] CfgIdxUnused = 4'd12;

  typedef struct {
    logic                      engine;
    logic [wmsc_pkg::ThrW-1:0] mode_lvl;
    logic [wmsc_pkg::ThrW-1:0] ivl_lvl;
  } tick_t;

  typedef struct {
    logic                       duty_valid;
    logic [wmsc_pkg::DutyW-1:0] duty;
    wmsc_pkg::mode_e            mode;
    wmsc_pkg::ivl_e             ivl;
    wmsc_pkg::phase_e           phase;
  } servo_word_t;

  logic                          clk;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [TickW-1:0]              s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [wmsc_pkg::OutW-1:0]     m_axis_tdata;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [wmsc_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [wmsc_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  // model state
  logic [wmsc_pkg::CfgDataW-1:0] reg_shadow [8];
  wmsc_pkg::mode_e               m_mode;
  wmsc_pkg::ivl_e                m_ivl;
  wmsc_pkg::phase_e              m_phase;
  logic [wmsc_pkg::DutyW-1:0]    m_rise;
  logic [wmsc_pkg::DutyW-1:0]    m_fall;
  logic [wmsc_pkg::ElapsedW-1:0] m_elapsed;
  logic [wmsc_pkg::TimerW-1:0]   m_timer;
  logic [wmsc_pkg::StepW-1:0]    m_steps;
  logic                          m_wrote;
  logic [wmsc_pkg::DutyW-1:0]    m_wrote_duty;

  tick_t       pending_ticks [$];
  servo_word_t duty_words_due [$];
  int          n_queued     = 0;
  int          n_accepted   = 0;
  int          n_errors     = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  logic        in_taken     = 1'b0;

  wiper_mode_sweep_controller DUT (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic logic [wmsc_pkg::ElapsedW-1:0] elapsed_plus_tick(
    input logic [wmsc_pkg::ElapsedW-1:0] e);
    int s;
    s = int'(e) + wmsc_pkg::TickMs;
    return (s > int'(wmsc_pkg::ElapsedMax)) ? wmsc_pkg::ElapsedMax
                                            : wmsc_pkg::ElapsedW'(s);
  endfunction

  function automatic logic [wmsc_pkg::TimerW-1:0] timer_plus_tick(
    input logic [wmsc_pkg::TimerW-1:0] t);
    int s;
    s = int'(t) + wmsc_pkg::TickMs;
    return (s > int'(wmsc_pkg::TimerMax)) ? wmsc_pkg::TimerMax : wmsc_pkg::TimerW'(s);
  endfunction

  task automatic servo_advance();
    case (m_phase)
      wmsc_pkg::PhHold: m_phase = wmsc_pkg::PhRise;
      wmsc_pkg::PhRise: begin
        if (m_rise < wmsc_pkg::DutyTop) m_rise = m_rise + 7'd1;
        m_wrote      = 1'b1;
        m_wrote_duty = m_rise;
        m_elapsed    = elapsed_plus_tick(m_elapsed);
        if (m_rise >= wmsc_pkg::DutyMax && m_elapsed >= wmsc_pkg::PhaseTimeMs) begin
          m_phase   = wmsc_pkg::PhFall;
          m_elapsed = '0;
          m_rise    = wmsc_pkg::DutyMin;
        end
      end
      wmsc_pkg::PhFall: begin
        if (m_fall != '0) m_fall = m_fall - 7'd1;
        m_wrote      = 1'b1;
        m_wrote_duty = m_fall;
        m_elapsed    = elapsed_plus_tick(m_elapsed);
        if (m_fall < wmsc_pkg::DutyMin && m_elapsed >= wmsc_pkg::PhaseTimeMs) begin
          m_phase   = wmsc_pkg::PhHold;
          m_elapsed = '0;
          m_fall    = wmsc_pkg::DutyMax;
        end
      end
      default: m_phase = wmsc_pkg::PhFall;
    endcase
  endtask

  // One tick of the wiper: mode pick, sweep or interval wait.
  task automatic next_servo_word(input tick_t t, output servo_word_t w);
    logic [wmsc_pkg::CfgDataW-1:0] goal_ms;
    m_wrote      = 1'b0;
    m_wrote_duty = '0;
    if (t.engine) begin
      if (t.mode_lvl > reg_shadow[wmsc_pkg::CfgModeHighThr][wmsc_pkg::ThrW-1:0])
        m_mode = wmsc_pkg::ModeInt;
      else if (t.mode_lvl > reg_shadow[wmsc_pkg::CfgModeLowThr][wmsc_pkg::ThrW-1:0])
        m_mode = wmsc_pkg::ModeHigh;
      else if (t.mode_lvl >= reg_shadow[wmsc_pkg::CfgModeOffThr][wmsc_pkg::ThrW-1:0])
        m_mode = wmsc_pkg::ModeLow;
      else
        m_mode = wmsc_pkg::ModeOff;
    end
    if (m_mode == wmsc_pkg::ModeOff) begin
      // finish a sweep under way, engine or not
      if (m_phase != wmsc_pkg::PhHold) servo_advance();
    end else if (m_mode == wmsc_pkg::ModeLow || m_mode == wmsc_pkg::ModeHigh) begin
      if (t.engine) servo_advance();
    end else if (t.engine) begin
      m_timer = timer_plus_tick(m_timer);
      if (t.ivl_lvl < reg_shadow[wmsc_pkg::CfgIvlShortThr][wmsc_pkg::ThrW-1:0])
        m_ivl = wmsc_pkg::IvlShort;
      else if (t.ivl_lvl > reg_shadow[wmsc_pkg::CfgIvlLongThr][wmsc_pkg::ThrW-1:0])
        m_ivl = wmsc_pkg::IvlLong;
      else
        m_ivl = wmsc_pkg::IvlMedium;
      case (m_ivl)
        wmsc_pkg::IvlShort:  goal_ms = reg_shadow[wmsc_pkg::CfgShortWait];
        wmsc_pkg::IvlMedium: goal_ms = reg_shadow[wmsc_pkg::CfgMediumWait];
        default:             goal_ms = reg_shadow[wmsc_pkg::CfgLongWait];
      endcase
      if (m_timer >= goal_ms) begin
        servo_advance();
        m_steps = m_steps + 7'd1;
        if (m_steps >= wmsc_pkg::StepLimit) begin
          m_timer = '0;
          m_steps = '0;
        end
      end else begin
        // hold the wiper parked while waiting
        m_wrote      = 1'b1;
        m_wrote_duty = wmsc_pkg::DutyMin;
        m_timer      = timer_plus_tick(m_timer);
      end
    end
    w.duty_valid = m_wrote;
    w.duty       = m_wrote_duty;
    w.mode       = m_mode;
    w.ivl        = m_ivl;
    w.phase      = m_phase;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      if (!s_axis_tvalid || in_taken) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          s_axis_tdata  <= {7'd0, pending_ticks[0].ivl_lvl, pending_ticks[0].mode_lvl,
                            pending_ticks[0].engine};
          s_axis_tvalid <= 1'b1;
          void'(pending_ticks.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    tick_t       t;
    servo_word_t got;
    servo_word_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (duty_words_due.size() == 0) begin
          report_mismatch($sformatf("output 0x%h with nothing expected", m_axis_tdata));
        end else begin
          want           = duty_words_due.pop_front();
          got.duty_valid = m_axis_tdata[0];
          got.duty       = m_axis_tdata[7:1];
          got.mode       = wmsc_pkg::mode_e'(m_axis_tdata[9:8]);
          got.ivl        = wmsc_pkg::ivl_e'(m_axis_tdata[11:10]);
          got.phase      = wmsc_pkg::phase_e'(m_axis_tdata[13:12]);
          check_field("duty_valid", got.duty_valid, want.duty_valid);
          check_field("duty_thousandths", got.duty, want.duty);
          check_field("active_mode", got.mode, want.mode);
          check_field("active_interval", got.ivl, want.ivl);
          check_field("sweep_phase", got.phase, want.phase);
          check_field("pad", m_axis_tdata[15:14], 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        t.engine   = s_axis_tdata[0];
        t.mode_lvl = s_axis_tdata[12:1];
        t.ivl_lvl  = s_axis_tdata[24:13];
        next_servo_word(t, want);
        duty_words_due.push_back(want);
        n_accepted++;
      end
    end
  end

  task automatic write_reg(input logic [wmsc_pkg::CfgIdxW-1:0] idx,
                           input logic [wmsc_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    if (idx <= wmsc_pkg::CfgIvlLongThr)
      reg_shadow[idx] = wmsc_pkg::CfgDataW'(val[wmsc_pkg::ThrW-1:0]);
    else if (idx <= wmsc_pkg::CfgLongWait)
      reg_shadow[idx] = val;
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_tick(input logic eng, input logic [wmsc_pkg::ThrW-1:0] m,
                           input logic [wmsc_pkg::ThrW-1:0] iv);
    tick_t t;
    t.engine   = eng;
    t.mode_lvl = m;
    t.ivl_lvl  = iv;
    pending_ticks.push_back(t);
    n_queued++;
  endtask

  function automatic logic [wmsc_pkg::ThrW-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return wmsc_pkg::ThrW'($urandom_range(0, 4095));
  endfunction

  // Runs of steady pot settings with engine drops and stray samples mixed in.
  task automatic push_random(input int n);
    int left;
    int run;
    int r;
    logic [wmsc_pkg::ThrW-1:0] m;
    logic [wmsc_pkg::ThrW-1:0] iv;
    left = n;
    while (left > 0) begin
      m   = pick_level();
      iv  = pick_level();
      run = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 60) : $urandom_range(60, 400);
      while (run > 0 && left > 0) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          push_tick(1'b0, wmsc_pkg::ThrW'($urandom_range(0, 4095)),
                    wmsc_pkg::ThrW'($urandom_range(0, 4095)));
        end else begin
          if (r < 12) push_tick(1'b1, pick_level(), pick_level());
          else push_tick(1'b1, m, iv);
          left--;
        end
        run--;
      end
    end
  endtask

  task automatic drain();
    while (n_accepted != n_queued || duty_words_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    reg_shadow[wmsc_pkg::CfgModeOffThr]  = wmsc_pkg::CfgDataW'(wmsc_pkg::RstModeOffThr);
    reg_shadow[wmsc_pkg::CfgModeLowThr]  = wmsc_pkg::CfgDataW'(wmsc_pkg::RstModeLowThr);
    reg_shadow[wmsc_pkg::CfgModeHighThr] = wmsc_pkg::CfgDataW'(wmsc_pkg::RstModeHighThr);
    reg_shadow[wmsc_pkg::CfgIvlShortThr] = wmsc_pkg::CfgDataW'(wmsc_pkg::RstIvlShortThr);
    reg_shadow[wmsc_pkg::CfgIvlLongThr]  = wmsc_pkg::CfgDataW'(wmsc_pkg::RstIvlLongThr);
    reg_shadow[wmsc_pkg::CfgShortWait]   = wmsc_pkg::RstShortWait;
    reg_shadow[wmsc_pkg::CfgMediumWait]  = wmsc_pkg::RstMediumWait;
    reg_shadow[wmsc_pkg::CfgLongWait]    = wmsc_pkg::RstLongWait;
    m_mode    = wmsc_pkg::ModeOff;
    m_ivl     = wmsc_pkg::IvlShort;
    m_phase   = wmsc_pkg::PhHold;
    m_rise    = wmsc_pkg::DutyMin;
    m_fall    = wmsc_pkg::DutyMax;
    m_elapsed = '0;
    m_timer   = '0;
    m_steps   = '0;
    snd_idle_pct = 28;
    rcv_idle_pct = 88;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // directed ticks at reset settings
    push_tick(1'b0, 12'd0, 12'd0);
    push_tick(1'b1, 12'd0, 12'd0);
    push_tick(1'b1, 12'd1023, 12'd4095);
    push_tick(1'b1, 12'd1024, 12'd0);      // hold enters rise, no duty
    push_tick(1'b1, 12'd2048, 12'd0);
    push_tick(1'b1, 12'd2049, 12'd0);
    push_tick(1'b1, 12'd3072, 12'd0);
    push_tick(1'b0, 12'd4095, 12'd4095);   // pots ignored, no motion
    push_tick(1'b1, 12'd0, 12'd0);         // off mode continues the sweep
    push_tick(1'b0, 12'd0, 12'd0);
    push_tick(1'b1, 12'd3073, 12'd0);
    push_tick(1'b1, 12'd4095, 12'd1351);
    push_tick(1'b1, 12'd4095, 12'd1352);
    push_tick(1'b1, 12'd4095, 12'd2744);
    push_tick(1'b1, 12'd4095, 12'd2745);
    push_tick(1'b1, 12'd4095, 12'd4095);
    push_tick(1'b0, 12'd0, 12'd0);
    push_tick(1'b1, 12'd1024, 12'd2000);
    push_tick(1'b1, 12'd2500, 12'd2000);
    push_tick(1'b1, 12'd1500, 12'd2000);
    drain();

    write_reg(wmsc_pkg::CfgModeOffThr, 14'd1024);
    write_reg(wmsc_pkg::CfgModeLowThr, 14'd2048);
    write_reg(wmsc_pkg::CfgModeHighThr, 14'd3072);
    write_reg(wmsc_pkg::CfgIvlShortThr, 14'd1352);
    write_reg(wmsc_pkg::CfgIvlLongThr, 14'd2744);
    write_reg(wmsc_pkg::CfgShortWait, 14'd100);
    write_reg(wmsc_pkg::CfgMediumWait, 14'd300);
    write_reg(wmsc_pkg::CfgLongWait, 14'd600);
    push_random(300);
    drain();
    push_random(300);
    drain();

    // extremes; upper data bits drop on the threshold registers
    snd_idle_pct = 88;
    rcv_idle_pct = 28;
    write_reg(wmsc_pkg::CfgModeOffThr, 14'h3FFF);
    write_reg(wmsc_pkg::CfgModeOffThr, 14'd0);
    write_reg(wmsc_pkg::CfgModeLowThr, 14'd0);
    write_reg(wmsc_pkg::CfgModeHighThr, 14'd0);
    write_reg(wmsc_pkg::CfgIvlShortThr, 14'h3FFF);
    write_reg(wmsc_pkg::CfgIvlLongThr, 14'h3FFF);
    write_reg(wmsc_pkg::CfgShortWait, 14'd0);
    write_reg(wmsc_pkg::CfgMediumWait, 14'h3FFF);
    write_reg(wmsc_pkg::CfgLongWait, 14'd0);
    write_reg(CfgIdxUnused, 14'd777);
    push_random(400);
    drain();

    write_reg(wmsc_pkg::CfgModeOffThr, 14'd4095);
    write_reg(wmsc_pkg::CfgModeLowThr, 14'd4095);
    write_reg(wmsc_pkg::CfgModeHighThr, 14'd4094);
    write_reg(wmsc_pkg::CfgIvlShortThr, 14'd0);
    write_reg(wmsc_pkg::CfgIvlLongThr, 14'd0);
    write_reg(wmsc_pkg::CfgShortWait, 14'h3FFF);
    write_reg(wmsc_pkg::CfgMediumWait, 14'd200);
    write_reg(wmsc_pkg::CfgLongWait, 14'h3FFF);
    push_random(300);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(wmsc_pkg::CfgModeOffThr, 14'($urandom_range(0, 4095)));
    write_reg(wmsc_pkg::CfgModeLowThr, 14'($urandom_range(0, 4095)));
    write_reg(wmsc_pkg::CfgModeHighThr, 14'($urandom_range(0, 4095)));
    write_reg(wmsc_pkg::CfgIvlShortThr, 14'($urandom_range(0, 4095)));
    write_reg(wmsc_pkg::CfgIvlLongThr, 14'($urandom_range(0, 4095)));
    write_reg(wmsc_pkg::CfgShortWait, 14'($urandom_range(0, 3000)));
    write_reg(wmsc_pkg::CfgMediumWait, 14'($urandom_range(0, 3000)));
    write_reg(wmsc_pkg::CfgLongWait, 14'($urandom_range(0, 3000)));
    push_random(700);
    drain();

    repeat (6) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wmsc_pkg.sv
hw/rtl/wmsc_step.sv
hw/rtl/wiper_mode_sweep_controller.sv
hw/rtl/wmsc_checker.sv
test/tb_wiper_mode_sweep_controller.sv
